// ===== rtl/assert_macros.svh =====
// Assertion macros included by the range conflict table top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/cawlrt_pkg.sv =====
// Types and constants of the range conflict table.
`timescale 1ns / 1ps
package cawlrt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam int LBA_W    = 64;
    localparam int CNT_W    = 32;
    localparam int TAG_W    = 16;
    localparam int HANDLE_W = 4;
    localparam int ACT_W    = 2;
    localparam int STAT_W   = 2;

    localparam logic [ACT_W-1:0] ACT_ADMIT      = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REM_HANDLE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REM_TAG    = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BUSY      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic             is_caw;
        logic [LBA_W-1:0] first_block;
        logic [LBA_W-1:0] last_block;
        logic [TAG_W-1:0] tag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/cawlrt_ifs.sv =====
// Request and response channel interfaces of the range conflict table.
`timescale 1ns / 1ps
interface cawlrt_req_if;
    import cawlrt_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACT_W-1:0]    action;
    logic [LBA_W-1:0]    lba;
    logic [CNT_W-1:0]    block_count;
    logic                is_compare_write;
    logic [TAG_W-1:0]    task_tag;
    logic [HANDLE_W-1:0] slot_handle;

    modport source (output valid, action, lba, block_count, is_compare_write, task_tag,
                    slot_handle, input ready);
    modport sink (input valid, action, lba, block_count, is_compare_write, task_tag,
                  slot_handle, output ready);
endinterface

interface cawlrt_rsp_if;
    import cawlrt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic [HANDLE_W-1:0] granted_handle;

    modport source (output valid, status, granted_handle, input ready);
    modport sink (input valid, status, granted_handle, output ready);
endinterface

// ===== rtl/cawlrt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cawlrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/caw_lba_range_conflict_table.sv =====
// Top level of the LBA range conflict table for compare-and-write serialization.
// Request channel i_req carries one word per action: admit a command range,
// remove by slot handle, or remove by task tag. Response channel o_rsp returns
// one word per request: status and, on a successful admit, the granted slot.
// Admit and remove by tag scan the entry RAM one slot per cycle through a
// single overlap / tag compare unit, then pass through a drain state to the
// done state, from which the response goes into the output register. Remove
// by handle and the unused action code skip the scan and go straight to the
// done state.
// The request side is ready only while the sequencer is idle. The response
// sits in an output register; a finished word waits in the sequencer while
// the receiver stalls, and the next request is taken once it has moved into
// the output register.
// Reset clears all valid bits, the sequencer and the output valid flag at once;
// entry payload in RAM is not cleared and is only read behind a valid bit.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module caw_lba_range_conflict_table #(
    parameter int TABLE_DEPTH = cawlrt_pkg::TABLE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cawlrt_req_if.sink   i_req,
    cawlrt_rsp_if.source o_rsp
);
    import cawlrt_pkg::*;

    localparam int IDXW = $clog2(TABLE_DEPTH);

    t_state r_state;
    t_state n_state;

    logic [ACT_W-1:0]    r_action;
    logic [LBA_W-1:0]    r_lba;
    logic [LBA_W-1:0]    r_last;
    logic                r_caw;
    logic [TAG_W-1:0]    r_tag;
    logic [HANDLE_W-1:0] r_handle;

    logic [IDXW-1:0]        r_idx;
    logic [IDXW-1:0]        r_cmp_idx;
    logic                   r_cmp_en;
    logic                   r_hit;
    logic [IDXW-1:0]        r_hit_idx;
    logic                   r_have_free;
    logic [IDXW-1:0]        r_free;
    logic [TABLE_DEPTH-1:0] r_valid;

    logic                r_out_valid;
    logic [STAT_W-1:0]   r_out_status;
    logic [HANDLE_W-1:0] r_out_grant;

    logic                req_fire;
    logic                done_fire;
    logic                scan_last;
    logic [LBA_W:0]      end_sum;
    logic [LBA_W-1:0]    in_last;
    logic [CNT_W-1:0]    span;
    logic [ENTRY_W-1:0]  ram_rdata;
    t_entry              rd_entry;
    t_entry              wr_entry;
    logic                cmp_valid;
    logic                overlap;
    logic                handle_ok;
    logic [IDXW-1:0]     handle_idx;
    logic [STAT_W-1:0]   fin_status;
    logic [HANDLE_W-1:0] fin_grant;
    logic                fin_set;
    logic                fin_clr;
    logic [IDXW-1:0]     fin_clr_idx;

    assign req_fire  = i_req.valid && i_req.ready;
    assign done_fire = (r_state == ST_DONE) && (!r_out_valid || o_rsp.ready);
    assign scan_last = (r_idx == IDXW'(TABLE_DEPTH - 1));

    // saturating inclusive end of the range; zero count counts as one
    assign span    = (i_req.block_count == '0) ? '0 : i_req.block_count - CNT_W'(1);
    assign end_sum = {1'b0, i_req.lba} + (LBA_W + 1)'(span);
    assign in_last = end_sum[LBA_W] ? '1 : end_sum[LBA_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (req_fire) begin
                    if ((i_req.action == ACT_ADMIT) || (i_req.action == ACT_REM_TAG)) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (done_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        i_req.ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
            end
            default: begin
                i_req.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_action <= i_req.action;
            r_lba    <= i_req.lba;
            r_last   <= in_last;
            r_caw    <= i_req.is_compare_write;
            r_tag    <= i_req.task_tag;
            r_handle <= i_req.slot_handle;
        end
    end

    // entry RAM
    assign wr_entry.is_caw      = r_caw;
    assign wr_entry.first_block = r_lba;
    assign wr_entry.last_block  = r_last;
    assign wr_entry.tag         = r_tag;

    cawlrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (done_fire && fin_set),
        .i_waddr (r_free),
        .i_wdata (wr_entry),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_entry  = t_entry'(ram_rdata);
    assign cmp_valid = r_valid[r_cmp_idx];
    assign overlap   = (r_lba <= rd_entry.last_block) && (rd_entry.first_block <= r_last);

    // scan: read address runs in the cycle before the compare stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_cmp_en    <= 1'b0;
            r_hit       <= 1'b0;
            r_have_free <= 1'b0;
        end else begin
            r_cmp_en <= (r_state == ST_SCAN);
            if (req_fire) begin
                r_idx       <= '0;
                r_hit       <= 1'b0;
                r_have_free <= 1'b0;
            end else begin
                if (r_state == ST_SCAN) begin
                    r_idx <= r_idx + IDXW'(1);
                end
                if (r_cmp_en) begin
                    if (r_action == ACT_ADMIT) begin
                        if (!cmp_valid && !r_have_free) begin
                            r_have_free <= 1'b1;
                        end
                        if (cmp_valid && overlap && (r_caw || rd_entry.is_caw)) begin
                            r_hit <= 1'b1;
                        end
                    end else if (cmp_valid && (rd_entry.tag == r_tag) && !r_hit) begin
                        r_hit <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_idx;
        if (r_cmp_en && !cmp_valid && !r_have_free) begin
            r_free <= r_cmp_idx;
        end
        if (r_cmp_en && cmp_valid && (rd_entry.tag == r_tag) && !r_hit) begin
            r_hit_idx <= r_cmp_idx;
        end
    end

    // completion
    assign handle_ok  = (32'(r_handle) < TABLE_DEPTH);
    assign handle_idx = IDXW'(r_handle);

    always_comb begin
        fin_status  = STAT_NOT_FOUND;
        fin_grant   = '0;
        fin_set     = 1'b0;
        fin_clr     = 1'b0;
        fin_clr_idx = r_hit_idx;
        case (r_action)
            ACT_ADMIT: begin
                if (r_hit) begin
                    fin_status = STAT_BUSY;
                end else if (!r_have_free) begin
                    fin_status = STAT_FULL;
                end else begin
                    fin_status = STAT_OK;
                    fin_grant  = HANDLE_W'(r_free);
                    fin_set    = 1'b1;
                end
            end
            ACT_REM_HANDLE: begin
                fin_clr_idx = handle_idx;
                if (handle_ok && r_valid[handle_idx]) begin
                    fin_status = STAT_OK;
                    fin_clr    = 1'b1;
                end
            end
            ACT_REM_TAG: begin
                if (r_hit) begin
                    fin_status = STAT_OK;
                    fin_clr    = 1'b1;
                end
            end
            default: begin
                fin_status = STAT_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (done_fire) begin
            if (fin_set) begin
                r_valid[r_free] <= 1'b1;
            end
            if (fin_clr) begin
                r_valid[fin_clr_idx] <= 1'b0;
            end
        end
    end

    // response word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_fire) begin
            r_out_status <= fin_status;
            r_out_grant  <= fin_grant;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.granted_handle = r_out_grant;

    `ASSERT_NEXT(a_scan_start, i_clk, i_rst_n,
        req_fire && ((i_req.action == ACT_ADMIT) || (i_req.action == ACT_REM_TAG)),
        (r_state == ST_SCAN) && (r_idx == '0))
    `ASSERT_NEXT(a_out_src, i_clk, i_rst_n,
        (r_state != ST_DONE) && !r_out_valid, !r_out_valid)
    `ASSERT_NEXT(a_grant_valid, i_clk, i_rst_n,
        done_fire && fin_set, r_valid[r_free] && (r_state == ST_IDLE))
    `ASSERT_ALWAYS(a_one_slot, i_clk, i_rst_n,
        $countones(r_valid ^ $past(r_valid)) <= 1)

endmodule

// ===== test/range_lock_sb_pkg.sv =====
// Scoreboard and word types for checking the LBA range conflict table.
`timescale 1ns / 1ps
package range_lock_sb_pkg;
    import cawlrt_pkg::*;

    localparam int LOCK_DEPTH = TABLE_DEPTH_DEF;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [ACT_W-1:0]    action;
        logic [LBA_W-1:0]    lba;
        logic [CNT_W-1:0]    block_count;
        logic                is_cw;
        logic [TAG_W-1:0]    tag;
        logic [HANDLE_W-1:0] handle;
    } lock_req_t;

    typedef struct {
        logic [STAT_W-1:0]   status;
        logic [HANDLE_W-1:0] grant;
    } lock_rsp_t;

    class range_lock_scoreboard;
        bit                  slot_valid [LOCK_DEPTH];
        bit                  slot_caw   [LOCK_DEPTH];
        logic [LBA_W-1:0]    slot_first [LOCK_DEPTH];
        logic [LBA_W-1:0]    slot_last  [LOCK_DEPTH];
        logic [TAG_W-1:0]    slot_tag   [LOCK_DEPTH];
        lock_rsp_t           pending_q[$];
        int                  errors;
        int                  checked;
        int                  requests;
        int                  status_seen [4];

        function new();
            errors   = 0;
            checked  = 0;
            requests = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            foreach (slot_valid[i]) slot_valid[i] = 1'b0;
        endfunction

        function lock_rsp_t admit(lock_req_t w);
            lock_rsp_t        r;
            logic [LBA_W-1:0] span;
            logic [LBA_W-1:0] top;
            int               free_idx;
            r.status = STAT_OK;
            r.grant  = '0;
            free_idx = -1;
            // zero count behaves as one block
            span = (w.block_count == '0) ? '0 : {32'b0, w.block_count} - 64'd1;
            // saturate at the top of the address space
            top  = (w.lba > ~span) ? '1 : w.lba + span;
            for (int i = 0; i < LOCK_DEPTH; i++) begin
                if (!slot_valid[i]) begin
                    if (free_idx < 0) free_idx = i;
                    continue;
                end
                if (w.lba <= slot_last[i] && slot_first[i] <= top &&
                    (w.is_cw || slot_caw[i])) begin
                    r.status = STAT_BUSY;
                    return r;
                end
            end
            if (free_idx < 0) begin
                r.status = STAT_FULL;
                return r;
            end
            slot_valid[free_idx] = 1'b1;
            slot_caw[free_idx]   = w.is_cw;
            slot_first[free_idx] = w.lba;
            slot_last[free_idx]  = top;
            slot_tag[free_idx]   = w.tag;
            r.grant = HANDLE_W'(free_idx);
            return r;
        endfunction

        function void note_request(lock_req_t w);
            lock_rsp_t r;
            r.status = STAT_NOT_FOUND;
            r.grant  = '0;
            case (w.action)
                ACT_ADMIT: begin
                    r = admit(w);
                end
                ACT_REM_HANDLE: begin
                    if (int'(w.handle) < LOCK_DEPTH && slot_valid[w.handle]) begin
                        slot_valid[w.handle] = 1'b0;
                        r.status = STAT_OK;
                    end
                end
                ACT_REM_TAG: begin
                    for (int i = 0; i < LOCK_DEPTH; i++) begin
                        if (slot_valid[i] && slot_tag[i] == w.tag) begin
                            slot_valid[i] = 1'b0;
                            r.status = STAT_OK;
                            break;
                        end
                    end
                end
                default: begin
                end
            endcase
            requests++;
            status_seen[r.status]++;
            pending_q.push_back(r);
        endfunction

        function int outstanding();
            return pending_q.size();
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch @%0t: %s", $time, msg);
        endtask

        task check_result(lock_rsp_t got);
            lock_rsp_t want;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected word: status %0d handle %0d",
                                 got.status, got.grant));
                return;
            end
            want = pending_q.pop_front();
            checked++;
            if (got.status !== want.status)
                report($sformatf("word %0d status %0d, want %0d",
                                 checked, got.status, want.status));
            if (got.grant !== want.grant)
                report($sformatf("word %0d granted_handle %0d, want %0d",
                                 checked, got.grant, want.grant));
        endtask
    endclass

endpackage

// ===== test/tb.sv =====
// Top level of the testbench for the LBA range conflict table.
`timescale 1ns / 1ps
module tb;
    import cawlrt_pkg::*;
    import range_lock_sb_pkg::*;

    localparam int STALL_PCT      = 29;
    localparam int RANDOM_WORDS   = 800;
    localparam int WATCHDOG_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;
    bit   calm;

    range_lock_scoreboard sb = new();

    cawlrt_req_if req_ch();
    cawlrt_rsp_if rsp_ch();

    caw_lba_range_conflict_table u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic lock_req_t make_word(logic [ACT_W-1:0] action, logic [LBA_W-1:0] lba,
                                            logic [CNT_W-1:0] cnt, logic is_cw,
                                            logic [TAG_W-1:0] tag,
                                            logic [HANDLE_W-1:0] handle);
        lock_req_t w;
        w.action      = action;
        w.lba         = lba;
        w.block_count = cnt;
        w.is_cw       = is_cw;
        w.tag         = tag;
        w.handle      = handle;
        return w;
    endfunction

    function automatic lock_req_t rand_word();
        lock_req_t w;
        int        pick;
        int        sel;
        int        live[$];
        pick = $urandom_range(99);
        for (int i = 0; i < LOCK_DEPTH; i++)
            if (sb.slot_valid[i]) live.push_back(i);
        w = make_word(ACT_ADMIT, {$urandom, $urandom}, $urandom, 1'($urandom_range(1)),
                      TAG_W'($urandom), HANDLE_W'($urandom));
        if (pick < 50) begin
            sel = $urandom_range(9);
            if (sel < 6) begin
                w.lba         = 64'h1000 + $urandom_range(63);
                w.block_count = $urandom_range(8, 1);
            end else if (sel < 8) begin
                w.lba = '1 - $urandom_range(63);
                if ($urandom_range(1)) w.block_count = $urandom_range(100, 1);
            end else if (sel == 9) begin
                w.lba         = 64'h1000 + $urandom_range(63);
                w.block_count = '0;
            end
            w.is_cw = ($urandom_range(99) < 30);
            if ($urandom_range(1)) w.tag = TAG_W'($urandom_range(7));
        end else if (pick < 70) begin
            w.action = ACT_REM_HANDLE;
            if (live.size() != 0)
                w.handle = HANDLE_W'(live[$urandom_range(live.size() - 1)]);
        end else if (pick < 85) begin
            w.action = ACT_REM_TAG;
            if (live.size() != 0) w.tag = sb.slot_tag[live[$urandom_range(live.size() - 1)]];
        end else if (pick < 95) begin
            w.action = $urandom_range(1) ? ACT_REM_HANDLE : ACT_REM_TAG;
        end else begin
            w.action = ACT_UNUSED;
        end
        return w;
    endfunction

    task automatic send_word(input lock_req_t w);
        while (!calm && $urandom_range(99) < STALL_PCT) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid            <= 1'b1;
        req_ch.action           <= w.action;
        req_ch.lba              <= w.lba;
        req_ch.block_count      <= w.block_count;
        req_ch.is_compare_write <= w.is_cw;
        req_ch.task_tag         <= w.tag;
        req_ch.slot_handle      <= w.handle;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        sb.note_request(w);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
    endtask

    // response side
    initial begin
        lock_rsp_t got;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
                got.status = rsp_ch.status;
                got.grant  = rsp_ch.granted_handle;
                sb.check_result(got);
            end
            rsp_ch.ready <= calm || ($urandom_range(99) >= STALL_PCT);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", quiet);
                $display("FAIL caw_lba_range_conflict_table");
                $finish;
            end
        end
    end

    initial begin
        calm                    <= 1'b0;
        i_rst_n                 <= 1'b0;
        req_ch.valid            <= 1'b0;
        req_ch.action           <= ACT_ADMIT;
        req_ch.lba              <= '0;
        req_ch.block_count      <= 32'd1;
        req_ch.is_compare_write <= 1'b0;
        req_ch.task_tag         <= '0;
        req_ch.slot_handle      <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // overlap rules, zero count, saturation, misses, lowest tag match
        send_word(make_word(ACT_ADMIT, 64'd0, 32'd1, 1'b0, 16'd1, 4'd0));
        send_word(make_word(ACT_ADMIT, 64'd0, 32'd0, 1'b1, 16'd2, 4'd0));
        send_word(make_word(ACT_ADMIT, 64'd1, 32'd0, 1'b1, 16'd2, 4'd0));
        send_word(make_word(ACT_ADMIT, 64'd1, 32'd5, 1'b0, 16'd3, 4'd0));
        send_word(make_word(ACT_ADMIT, 64'd0, 32'd1, 1'b0, 16'd1, 4'd0));
        send_word(make_word(ACT_ADMIT, 64'hFFFF_FFFF_FFFF_FFFC, 32'hFFFF_FFFF, 1'b1,
                            16'hFFFF, 4'hF));
        send_word(make_word(ACT_ADMIT, '1, 32'd1, 1'b0, 16'd0, 4'd0));
        send_word(make_word(ACT_REM_HANDLE, '1, '1, 1'b1, '1, 4'hF));
        send_word(make_word(ACT_REM_TAG, 64'd0, 32'd1, 1'b0, 16'h1234, 4'd0));
        send_word(make_word(ACT_UNUSED, '1, '1, 1'b1, '1, '1));
        send_word(make_word(ACT_REM_TAG, 64'd0, 32'd1, 1'b0, 16'd1, 4'd0));
        send_word(make_word(ACT_REM_HANDLE, 64'd0, 32'd1, 1'b0, 16'd0, 4'd2));
        wait_drained();
        // fill the table, then one more; then busy while full
        for (int i = 0; i < LOCK_DEPTH - 1; i++)
            send_word(make_word(ACT_ADMIT, 64'h100 + i, 32'd1, 1'b0, 16'h40 + 16'(i), 4'd0));
        send_word(make_word(ACT_ADMIT, 64'h100, 32'd1, 1'b1, 16'h77, 4'd0));
        send_word(make_word(ACT_REM_HANDLE, 64'd0, 32'd1, 1'b0, 16'd0, 4'hF));
        wait_drained();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            calm <= (n >= 400 && n < 520);
            if (n % 200 == 199) wait_drained();
            send_word(rand_word());
        end
        req_ch.valid <= 1'b0;
        calm         <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (2 * LOCK_DEPTH + 8) @(posedge i_clk);

        $display("ran %0d requests, %0d responses checked, %0d mismatches",
                 sb.requests, sb.checked, sb.errors);
        $display("status mix: ok %0d, busy %0d, full %0d, not found %0d",
                 sb.status_seen[STAT_OK], sb.status_seen[STAT_BUSY],
                 sb.status_seen[STAT_FULL], sb.status_seen[STAT_NOT_FOUND]);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("PASS caw_lba_range_conflict_table");
        end else begin
            $display("FAIL caw_lba_range_conflict_table");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/cawlrt_pkg.sv
rtl/cawlrt_ifs.sv
rtl/cawlrt_ram.sv
rtl/caw_lba_range_conflict_table.sv
test/range_lock_sb_pkg.sv
test/tb.sv
